/* src/q5_q8_block_dot_accumulator_assert.svh */
// Assertion macros for the q5/q8 block dot accumulator.
`ifndef Q5_Q8_BLOCK_DOT_ACCUMULATOR_ASSERT_SVH
`define Q5_Q8_BLOCK_DOT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define Q5Q8_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define Q5Q8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/q5q8_pkg.sv */
// Shared types, constants and fp32 helper functions for the q5/q8 block dot accumulator.
`default_nettype none
package q5q8_pkg;

   localparam int BLOCK_ELEMS = 32;
   localparam int HALF_ELEMS  = BLOCK_ELEMS / 2;
   localparam int LANE_COUNT  = 8;
   localparam int LANE_ELEMS  = BLOCK_ELEMS / LANE_COUNT;
   localparam int CODE_W      = 5;
   localparam int ACT_W       = 8;
   localparam int LANE_SUM_W  = 15;
   localparam int DOT_SUM_W   = 18;
   localparam logic [7:0]  NIB_LO_MASK = 8'h0F;
   localparam logic [31:0] FP32_QNAN   = 32'h7FC0_0000;
   localparam logic [31:0] FP32_ZERO   = 32'h0000_0000;

   typedef logic [CODE_W-1:0]            code_type;
   typedef logic signed [ACT_W-1:0]      act_type;
   typedef logic signed [LANE_SUM_W-1:0] lane_sum_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LANE,
      ST_MERGE,
      ST_MAIN,
      ST_BLOCK,
      ST_ACCUM,
      ST_BIAS
   } seq_state_type;

   // Leading zero count of a 51-bit word (zero input gives 0, never used).
   function automatic logic [5:0] lead_zeros(input logic [50:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 51; i++) begin
         if (v[i]) begin
            n = 6'(50 - i);
         end
      end
      return n;
   endfunction

   // Round to nearest even and pack. mant has its leading one at bit 47.
   function automatic logic [31:0] round_pack(input logic sign,
                                              input logic signed [10:0] ex,
                                              input logic [47:0] mant,
                                              input logic sticky);
      logic [47:0] m2;
      logic        lost;
      logic [5:0]  sh;
      logic [7:0]  ef;
      logic [22:0] fr;
      logic        g;
      logic        s;
      logic [30:0] mag;
      logic signed [10:0] d;
      m2   = mant;
      lost = 1'b0;
      ef   = 8'd0;
      sh   = 6'd0;
      d    = 11'sd1 - ex;
      if (ex >= 11'sd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      if (ex >= 11'sd1) begin
         ef = ex[7:0];
      end else begin
         sh   = (d > 11'sd63) ? 6'd63 : d[5:0];
         m2   = mant >> sh;
         lost = ((m2 << sh) != mant);
      end
      fr  = m2[46:24];
      g   = m2[23];
      s   = (|m2[22:0]) | lost | sticky;
      mag = {ef, fr} + {30'd0, g & (s | fr[0])};
      return {sign, mag};
   endfunction

   function automatic logic is_nan(input logic [31:0] a);
      return (&a[30:23]) && (|a[22:0]);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return (&a[30:23]) && !(|a[22:0]);
   endfunction

   // fp32 multiply, all IEEE cases, round to nearest even.
   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        s;
      logic        az;
      logic        bz;
      logic [23:0] ma;
      logic [23:0] mb;
      logic signed [10:0] ea;
      logic signed [10:0] eb;
      logic [47:0] p;
      logic [5:0]  lz;
      logic [47:0] mant;
      logic signed [10:0] ex;
      s  = a[31] ^ b[31];
      az = (a[30:0] == 31'd0);
      bz = (b[30:0] == 31'd0);
      if (is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (is_inf(b) && az)) begin
         return FP32_QNAN;
      end
      if (is_inf(a) || is_inf(b)) begin
         return {s, 8'hFF, 23'd0};
      end
      if (az || bz) begin
         return {s, 31'd0};
      end
      ma   = {|a[30:23], a[22:0]};
      mb   = {|b[30:23], b[22:0]};
      ea   = (a[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, a[30:23]});
      eb   = (b[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, b[30:23]});
      p    = ma * mb;
      lz   = lead_zeros({p, 3'b000});
      mant = p << lz;
      ex   = ea + eb - 11'sd126 - $signed({5'd0, lz});
      return round_pack(s, ex, mant, 1'b0);
   endfunction

   // fp32 add, all IEEE cases, round to nearest even.
   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      logic        az;
      logic        bz;
      logic [7:0]  ex_x;
      logic [7:0]  ex_y;
      logic [7:0]  d;
      logic [5:0]  sh;
      logic [50:0] big;
      logic [50:0] yb;
      logic [50:0] ys;
      logic [50:0] r;
      logic [50:0] nm;
      logic [5:0]  lz;
      logic signed [10:0] ex;
      az = (a[30:0] == 31'd0);
      bz = (b[30:0] == 31'd0);
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
         return FP32_QNAN;
      end
      if (is_inf(a)) begin
         return a;
      end
      if (is_inf(b)) begin
         return b;
      end
      if (az && bz) begin
         return {a[31] & b[31], 31'd0};
      end
      if (az) begin
         return b;
      end
      if (bz) begin
         return a;
      end
      if (a[30:0] < b[30:0]) begin
         x = b;
         y = a;
      end else begin
         x = a;
         y = b;
      end
      ex_x = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ex_y = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d    = ex_x - ex_y;
      sh   = (d > 8'd63) ? 6'd63 : d[5:0];
      big  = {1'b0, |x[30:23], x[22:0], 26'd0};
      yb   = {1'b0, |y[30:23], y[22:0], 26'd0};
      ys   = yb >> sh;
      ys[0] = ys[0] | ((ys << sh) != yb);
      r    = (x[31] == y[31]) ? (big + ys) : (big - ys);
      if (r == 51'd0) begin
         return FP32_ZERO;
      end
      lz = lead_zeros(r);
      nm = r << lz;
      ex = $signed({3'd0, ex_x}) + 11'sd1 - $signed({5'd0, lz});
      return round_pack(x[31], ex, nm[50:3], |nm[2:0]);
   endfunction

   // Exact fp16 to fp32, subnormals normalized.
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [3:0] lz;
      logic [9:0] m;
      logic [9:0] fr;
      m  = h[9:0];
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            lz = 4'(9 - i);
         end
      end
      fr = 10'(m << (lz + 4'd1));
      if (h[14:10] == 5'h1F) begin
         return {h[15], 8'hFF, m, 13'd0};
      end else if (h[14:10] != 5'd0) begin
         return {h[15], {3'd0, h[14:10]} + 8'd112, m, 13'd0};
      end else if (m == 10'd0) begin
         return {h[15], 31'd0};
      end
      return {h[15], 8'd112 - {4'd0, lz}, fr, 13'd0};
   endfunction

endpackage
`default_nettype wire

/* src/q5q8_lane.sv */
// One dot-product lane: four code by activation products, summed and registered.
`default_nettype none
module q5q8_lane (
   input  wire logic                                          clock,
   input  wire q5q8_pkg::code_type [q5q8_pkg::LANE_ELEMS-1:0] codes,
   input  wire q5q8_pkg::act_type  [q5q8_pkg::LANE_ELEMS-1:0] acts,
   output q5q8_pkg::lane_sum_type                             lane_sum_ff
);
   import q5q8_pkg::*;

   lane_sum_type lane_sum_in;

   always_comb begin
      lane_sum_in = '0;
      for (int i = 0; i < LANE_ELEMS; i++) begin
         lane_sum_in = lane_sum_in
            + LANE_SUM_W'($signed({1'b0, codes[i]}) * acts[i]);
      end
   end

   always_ff @(posedge clock) begin
      lane_sum_ff <= lane_sum_in;
   end

endmodule
`default_nettype wire

/* src/q5q8_merge.sv */
// Merging stage: adds the lane sums and converts the block integer sum to fp32.
`default_nettype none
module q5q8_merge (
   input  wire logic                                              clock,
   input  wire q5q8_pkg::lane_sum_type [q5q8_pkg::LANE_COUNT-1:0] lane_sums,
   output logic [31:0]                                            sum_fp_ff
);
   import q5q8_pkg::*;

   logic signed [DOT_SUM_W-1:0] total;
   logic [DOT_SUM_W-2:0]        mag;
   logic [DOT_SUM_W-2:0]        norm;
   logic [4:0]                  lz;
   logic [31:0]                 sum_fp_in;

   always_comb begin
      total = '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         total = total + DOT_SUM_W'(lane_sums[i]);
      end
      mag = total[DOT_SUM_W-1] ? (DOT_SUM_W-1)'(-total) : total[DOT_SUM_W-2:0];
      lz  = 5'd0;
      for (int i = 0; i < DOT_SUM_W - 1; i++) begin
         if (mag[i]) begin
            lz = 5'(DOT_SUM_W - 2 - i);
         end
      end
      norm = mag << lz;
      // |sum| < 2^17, so the conversion is exact
      if (total == '0) begin
         sum_fp_in = FP32_ZERO;
      end else begin
         sum_fp_in = {total[DOT_SUM_W-1], 8'd143 - {3'd0, lz},
                      norm[DOT_SUM_W-3:0], 7'd0};
      end
   end

   always_ff @(posedge clock) begin
      sum_fp_ff <= sum_fp_in;
   end

endmodule
`default_nettype wire

/* src/q5_q8_block_dot_accumulator.sv */
// Top level: q5/q8 block dot product with fp32 row accumulation and bias.
//
//  channel | ports            | carries
//  --------+------------------+------------------------------------------------
//  req     | req_t*           | one weight/activation block pair, tlast = last_block
//  rsp     | rsp_t*           | fp32 row result plus bias, one per last block
//
// Items go one at a time, with a bias step when one closes a row: lanes, merge,
// then one shared fp32 multiplier and one shared fp32 adder used once per step,
// in row order. The row accumulator add is the serial loop.
// Reset (synchronous, active high) clears the sequencer, the accumulator to +0
// and the result valid. A stalled result waits in the output register; the
// next item is accepted meanwhile and only a closing row waits for it.
`default_nettype none
`include "q5_q8_block_dot_accumulator_assert.svh"
module q5_q8_block_dot_accumulator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // weight_scales, weight_high_bits, weight_nibbles_a, weight_nibbles_b,
   // act_scales, act_quants_0, act_quants_1, act_quants_2, act_quants_3, bias_value
   input  wire logic [511:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_value
   output logic [31:0]       rsp_tdata
);
   import q5q8_pkg::*;

   seq_state_type state_ff, state_in;

   // item registers
   logic [31:0]  wscale_ff;
   logic [31:0]  hbits_ff;
   logic [127:0] nibs_ff;
   logic [31:0]  ascale_ff;
   logic [255:0] quants_ff;
   logic         last_ff;
   logic [31:0]  bias_ff;

   // fp intermediates
   logic [31:0] t_scale_ff;
   logic [31:0] t_min_ff;
   logic [31:0] t_main_ff;
   logic [31:0] t_blk_ff;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] rsp_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   code_type     [BLOCK_ELEMS-1:0] codes;
   act_type      [BLOCK_ELEMS-1:0] acts;
   lane_sum_type [LANE_COUNT-1:0]  lane_sums;
   logic [31:0] sum_fp;

   logic [31:0] mul_a, mul_b, mul_y;
   logic [31:0] add_a, add_b, add_y;
   logic [31:0] result_bits;
   logic        out_free;
   logic        accept;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // weight code unpack: low nibble + bit i, high nibble + bit i+16
   always_comb begin
      for (int i = 0; i < HALF_ELEMS; i++) begin
         codes[i]              = {hbits_ff[i], nibs_ff[8*i +: 4] & NIB_LO_MASK[3:0]};
         codes[i + HALF_ELEMS] = {hbits_ff[i + HALF_ELEMS], nibs_ff[8*i + 4 +: 4]};
      end
      for (int i = 0; i < BLOCK_ELEMS; i++) begin
         acts[i] = $signed(quants_ff[8*i +: 8]);
      end
   end

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
      q5q8_lane u_lane (
         .clock       (clock),
         .codes       (codes[LANE_ELEMS*l +: LANE_ELEMS]),
         .acts        (acts[LANE_ELEMS*l +: LANE_ELEMS]),
         .lane_sum_ff (lane_sums[l])
      );
   end

   q5q8_merge u_merge (
      .clock     (clock),
      .lane_sums (lane_sums),
      .sum_fp_ff (sum_fp)
   );

   // shared multiplier: wd*xd, then wm*xs, then scale*sum
   always_comb begin
      unique case (state_ff)
         ST_LANE: begin
            mul_a = half_to_single(wscale_ff[15:0]);
            mul_b = half_to_single(ascale_ff[15:0]);
         end
         ST_MERGE: begin
            mul_a = half_to_single(wscale_ff[31:16]);
            mul_b = half_to_single(ascale_ff[31:16]);
         end
         default: begin
            mul_a = t_scale_ff;
            mul_b = sum_fp;
         end
      endcase
      mul_y = fp_mul(mul_a, mul_b);
   end

   // shared adder: main+min, acc+block, acc+bias
   always_comb begin
      unique case (state_ff)
         ST_BLOCK: begin
            add_a = t_main_ff;
            add_b = t_min_ff;
         end
         ST_ACCUM: begin
            add_a = acc_ff;
            add_b = t_blk_ff;
         end
         default: begin
            add_a = acc_ff;
            add_b = bias_ff;
         end
      endcase
      add_y       = fp_add(add_a, add_b);
      result_bits = is_nan(add_y) ? FP32_QNAN : add_y;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_LANE;
         ST_LANE:  state_in = ST_MERGE;
         ST_MERGE: state_in = ST_MAIN;
         ST_MAIN:  state_in = ST_BLOCK;
         ST_BLOCK: state_in = ST_ACCUM;
         ST_ACCUM: state_in = last_ff ? ST_BIAS : ST_IDLE;
         ST_BIAS:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_ACCUM: acc_in = add_y;
         ST_BIAS: begin
            if (out_free) begin
               acc_in       = FP32_ZERO;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= FP32_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wscale_ff <= req_tdata[31:0];
         hbits_ff  <= req_tdata[63:32];
         nibs_ff   <= req_tdata[191:64];
         ascale_ff <= req_tdata[223:192];
         quants_ff <= req_tdata[479:224];
         bias_ff   <= req_tdata[511:480];
         last_ff   <= req_tlast;
      end
      if (state_ff == ST_LANE)  t_scale_ff <= mul_y;
      if (state_ff == ST_MERGE) t_min_ff   <= mul_y;
      if (state_ff == ST_MAIN)  t_main_ff  <= mul_y;
      if (state_ff == ST_BLOCK) t_blk_ff   <= add_y;
      if (state_ff == ST_BIAS && out_free) rsp_data_ff <= result_bits;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `Q5Q8_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_LANE, "accept did not start lanes")
   `Q5Q8_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_tready, "ready while busy")
   `Q5Q8_ASSERT_SAME(a_bias_only_last, clock, reset, state_ff == ST_BIAS, last_ff, "bias step on a non-last block")
   `Q5Q8_ASSERT_NEXT(a_emit_clears, clock, reset, (state_ff == ST_BIAS) && out_free, (acc_ff == FP32_ZERO) && rsp_valid_ff, "row emit did not clear accumulator")

endmodule
`default_nettype wire
